>>> rtl/fekc_pkg.sv
// ----------------------------------------------------------------------------
// fekc_pkg
// shared types and codes of the fifo-evicting key cache
// ----------------------------------------------------------------------------
package fekc_pkg;

  localparam int KEY_W   = 64;
  localparam int SEQ_W   = 64;
  localparam int CMD_W   = 2;
  localparam int LIMIT_W = 5;
  localparam int OUT_PW  = 32;
  localparam int TOTAL_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // flags of the search probe that walks the cell chain
  typedef struct packed {
    logic vld;
    logic match;
    logic old_found;
    logic free_found;
  } probe_flags_t;

  // update broadcast to every cell
  typedef struct packed {
    logic clr;
    logic evict;
    logic write;
  } wr_ctrl_t;

endpackage

>>> rtl/fekc_cell.sv
// ----------------------------------------------------------------------------
// fekc_cell
// one cache slot plus one stage of the search probe chain
// ----------------------------------------------------------------------------
module fekc_cell
  import fekc_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int PW    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // probe from the previous cell
  input  probe_flags_t        flags_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [PW-1:0]       pay_i,
  input  logic [IDX_W-1:0]    midx_i,
  input  logic [IDX_W-1:0]    oidx_i,
  input  logic [SEQ_W-1:0]    oseq_i,
  input  logic [IDX_W-1:0]    fidx_i,
  input  logic [CNT_W-1:0]    cnt_i,
  // probe to the next cell
  output probe_flags_t        flags_o,
  output logic [KEY_W-1:0]    key_o,
  output logic [PW-1:0]       pay_o,
  output logic [IDX_W-1:0]    midx_o,
  output logic [IDX_W-1:0]    oidx_o,
  output logic [SEQ_W-1:0]    oseq_o,
  output logic [IDX_W-1:0]    fidx_o,
  output logic [CNT_W-1:0]    cnt_o,
  // update broadcast
  input  wr_ctrl_t            wr_i,
  input  logic [IDX_W-1:0]    wr_tgt_i,
  input  logic [IDX_W-1:0]    wr_evict_i,
  input  logic [KEY_W-1:0]    wr_key_i,
  input  logic [PW-1:0]       wr_pay_i,
  input  logic [SEQ_W-1:0]    wr_seq_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q;
  logic [PW-1:0]    pay_q;
  logic [SEQ_W-1:0] seq_q;

  probe_flags_t     flags_q, flags_d;
  logic [KEY_W-1:0] pkey_q;
  logic [PW-1:0]    ppay_q, ppay_d;
  logic [IDX_W-1:0] midx_q, midx_d, oidx_q, oidx_d, fidx_q, fidx_d;
  logic [SEQ_W-1:0] oseq_q, oseq_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic hit_here, older_here, free_here, write_here;

  assign write_here = wr_i.write && (wr_tgt_i == MY_IDX);

  // slot update: a clear wins, then a write to the same slot wins over an evict
  always_comb begin
    valid_d = valid_q;
    if (wr_i.clr) begin
      valid_d = 1'b0;
    end else if (write_here) begin
      valid_d = 1'b1;
    end else if (wr_i.evict && (wr_evict_i == MY_IDX)) begin
      valid_d = 1'b0;
    end
  end

  // merge this slot into the passing probe
  always_comb begin
    hit_here   = valid_q && (key_q == key_i);
    older_here = valid_q && (!flags_i.old_found || (seq_q < oseq_i));
    free_here  = !valid_q && !flags_i.free_found;

    flags_d            = flags_i;
    flags_d.match      = flags_i.match || hit_here;
    flags_d.old_found  = flags_i.old_found || valid_q;
    flags_d.free_found = flags_i.free_found || !valid_q;

    midx_d = (hit_here && !flags_i.match) ? MY_IDX : midx_i;
    ppay_d = (hit_here && !flags_i.match) ? pay_q : pay_i;
    oidx_d = older_here ? MY_IDX : oidx_i;
    oseq_d = older_here ? seq_q : oseq_i;
    fidx_d = free_here ? MY_IDX : fidx_i;
    cnt_d  = cnt_i + CNT_W'(valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_here) begin
      key_q <= wr_key_i;
      pay_q <= wr_pay_i;
      seq_q <= wr_seq_i;
    end
    pkey_q <= key_i;
    ppay_q <= ppay_d;
    midx_q <= midx_d;
    oidx_q <= oidx_d;
    oseq_q <= oseq_d;
    fidx_q <= fidx_d;
    cnt_q  <= cnt_d;
  end

  assign flags_o = flags_q;
  assign key_o   = pkey_q;
  assign pay_o   = ppay_q;
  assign midx_o  = midx_q;
  assign oidx_o  = oidx_q;
  assign oseq_o  = oseq_q;
  assign fidx_o  = fidx_q;
  assign cnt_o   = cnt_q;

endmodule

>>> rtl/fifo_evicting_key_cache.sv
// ----------------------------------------------------------------------------
// fifo_evicting_key_cache
// fully associative key cache with oldest-first eviction, built as a chain
// of slot cells that a search probe walks one cell per cycle
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | cmd_i, key_i, payload_in_i
//  out     | output    | out_valid_o / out_stall_i | hit_o, payload_out_o,
//          |           |                           | hit_total_o
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (entry_limit)
//
//  - one request at a time: the next request is accepted only after the probe has
//    walked the DEPTH-cell chain, been captured and the update has fired
//  - every command walks the chain, so lookup, insert and clear take equally long
//  - rst_ni empties the table, zeroes the sequence and hit counters, and sets
//    entry_limit to 16
//  - a stalled response holds in the output register; the block waits in its
//    update cycle until the register frees, and accepts the next request while
//    the last response is still waiting
//
module fifo_evicting_key_cache
  import fekc_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [OUT_PW-1:0]    payload_in_i,
  // response channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic [OUT_PW-1:0]    payload_out_o,
  output logic [TOTAL_W-1:0]   hit_total_o
);

  // stored payload width: the handle never carries more than the port has
  localparam int PW    = (PAYLOAD_BITS < OUT_PW) ? PAYLOAD_BITS : OUT_PW;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   accept, cap, fire;

  logic [LIMIT_W-1:0] limit_q;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [TOTAL_W-1:0] hit_cnt_q, hit_cnt_d;

  // request held for the update cycle
  logic [CMD_W-1:0]   req_cmd_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [PW-1:0]      req_pay_q;

  // probe as it leaves the chain, captured
  probe_flags_t       cap_flags_q;
  logic [PW-1:0]      cap_pay_q;
  logic [IDX_W-1:0]   cap_midx_q, cap_oidx_q, cap_fidx_q;
  logic [CNT_W-1:0]   cap_cnt_q;

  // response register
  logic               out_valid_q;
  logic               hit_q;
  logic [OUT_PW-1:0]  pay_out_q;
  logic [TOTAL_W-1:0] total_q;

  // --------------------------------------------------------------------------
  // cell chain: index 0 is the injection point, index DEPTH the tail
  // --------------------------------------------------------------------------
  probe_flags_t     ch_flags [DEPTH+1];
  logic [KEY_W-1:0] ch_key   [DEPTH+1];
  logic [PW-1:0]    ch_pay   [DEPTH+1];
  logic [IDX_W-1:0] ch_midx  [DEPTH+1];
  logic [IDX_W-1:0] ch_oidx  [DEPTH+1];
  logic [SEQ_W-1:0] ch_oseq  [DEPTH+1];
  logic [IDX_W-1:0] ch_fidx  [DEPTH+1];
  logic [CNT_W-1:0] ch_cnt   [DEPTH+1];
  logic [DEPTH:0]   ch_vld;
  probe_flags_t     inj_flags;

  wr_ctrl_t         wr;
  logic [IDX_W-1:0] wr_tgt;

  // a fresh probe enters only on an accepted request
  always_comb begin
    inj_flags     = '0;
    inj_flags.vld = accept;
  end

  assign ch_flags[0] = inj_flags;
  assign ch_key[0]   = key_i;
  assign ch_pay[0]   = '0;
  assign ch_midx[0]  = '0;
  assign ch_oidx[0]  = '0;
  assign ch_oseq[0]  = '0;
  assign ch_fidx[0]  = '0;
  assign ch_cnt[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fekc_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .PW    (PW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .flags_i    (ch_flags[g]),
      .key_i      (ch_key[g]),
      .pay_i      (ch_pay[g]),
      .midx_i     (ch_midx[g]),
      .oidx_i     (ch_oidx[g]),
      .oseq_i     (ch_oseq[g]),
      .fidx_i     (ch_fidx[g]),
      .cnt_i      (ch_cnt[g]),
      .flags_o    (ch_flags[g+1]),
      .key_o      (ch_key[g+1]),
      .pay_o      (ch_pay[g+1]),
      .midx_o     (ch_midx[g+1]),
      .oidx_o     (ch_oidx[g+1]),
      .oseq_o     (ch_oseq[g+1]),
      .fidx_o     (ch_fidx[g+1]),
      .cnt_o      (ch_cnt[g+1]),
      .wr_i       (wr),
      .wr_tgt_i   (wr_tgt),
      .wr_evict_i (cap_oidx_q),
      .wr_key_i   (req_key_q),
      .wr_pay_i   (req_pay_q),
      .wr_seq_i   (seq_q)
    );
  end

  for (genvar v = 0; v <= DEPTH; v++) begin : g_vld
    assign ch_vld[v] = ch_flags[v].vld;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (ch_vld[DEPTH]) state_d = ST_WRITE;
      ST_WRITE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    cap        = 1'b0;
    fire       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_SCAN:  cap  = ch_vld[DEPTH];
      ST_WRITE: fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // update decision from the captured probe
  // --------------------------------------------------------------------------
  logic              is_insert, at_limit, evict, match_eff, do_write;
  logic              lookup_hit;
  logic [OUT_PW-1:0] hit_pay;

  always_comb begin
    is_insert = (req_cmd_q == CMD_INSERT);
    // a limit above DEPTH acts as DEPTH: a full table always evicts
    at_limit  = (CMP_W'(cap_cnt_q) >= CMP_W'(limit_q)) || (cap_cnt_q == CNT_W'(DEPTH));
    evict     = is_insert && cap_flags_q.old_found && at_limit;
    // a key whose own slot was just evicted is not found again
    match_eff = cap_flags_q.match && !(evict && (cap_midx_q == cap_oidx_q));
    do_write  = is_insert && (match_eff || evict || cap_flags_q.free_found);

    // target: matching slot, else lowest free slot after the eviction
    if (match_eff) begin
      wr_tgt = cap_midx_q;
    end else if (evict && (!cap_flags_q.free_found || (cap_oidx_q < cap_fidx_q))) begin
      wr_tgt = cap_oidx_q;
    end else begin
      wr_tgt = cap_fidx_q;
    end

    wr.clr   = fire && (req_cmd_q == CMD_CLEAR);
    wr.evict = fire && evict;
    wr.write = fire && do_write;

    lookup_hit      = (req_cmd_q == CMD_LOOKUP) && cap_flags_q.match;
    hit_pay         = '0;
    hit_pay[PW-1:0] = cap_pay_q;
  end

  always_comb begin
    seq_d     = seq_q;
    hit_cnt_d = hit_cnt_q;
    case (req_cmd_q)
      CMD_LOOKUP: if (lookup_hit) hit_cnt_d = hit_cnt_q + TOTAL_W'(1);
      CMD_INSERT: if (do_write) seq_d = seq_q + SEQ_W'(1);
      CMD_CLEAR: begin
        seq_d     = '0;
        hit_cnt_d = '0;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RST;
      seq_q       <= '0;
      hit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      cap_flags_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cap) begin
        cap_flags_q <= ch_flags[DEPTH];
      end
      if (fire) begin
        seq_q       <= seq_d;
        hit_cnt_q   <= hit_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_cmd_q <= cmd_i;
      req_key_q <= key_i;
      req_pay_q <= payload_in_i[PW-1:0];
    end
    if (cap) begin
      cap_pay_q  <= ch_pay[DEPTH];
      cap_midx_q <= ch_midx[DEPTH];
      cap_oidx_q <= ch_oidx[DEPTH];
      cap_fidx_q <= ch_fidx[DEPTH];
      cap_cnt_q  <= ch_cnt[DEPTH];
    end
    if (fire) begin
      hit_q     <= lookup_hit;
      pay_out_q <= lookup_hit ? hit_pay : '0;
      total_q   <= hit_cnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign payload_out_o = pay_out_q;
  assign hit_total_o   = total_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_one_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(ch_vld) <= 1)
    else $error("more than one probe in the cell chain");

  a_tail_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_vld[DEPTH] |-> (state_q == ST_SCAN))
    else $error("probe left the chain outside the scan phase");

  a_clear_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_cmd_q == CMD_CLEAR)) |=> (hit_total_o == '0))
    else $error("clear did not zero the hit total");

  a_miss_no_pay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (payload_out_o == '0))
    else $error("payload reported without a hit");

endmodule
